// File: design/rcus_pkg.sv
// Package: constants, codes and types for the ring capture read-out sequencer.
`default_nettype none

package rcus_pkg;

    // Buffer geometry
    localparam int unsigned BUFFER_BYTES = 524288;
    localparam int unsigned PTR_W        = $clog2(BUFFER_BYTES);
    localparam int unsigned LEN_W        = PTR_W + 1;
    localparam int unsigned HEADER_BYTES = 15;

    // Stream field widths
    localparam int unsigned OP_W    = 2;
    localparam int unsigned TOTAL_W = 64;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned IN_TDATA_W  = 88;
    localparam int unsigned OUT_TDATA_W = 128;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_ID       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONEHOT_SELECT = 1'd1;

    // Saturation limit of the consumed and sent offsets
    localparam logic [LEN_W-1:0] OFS_MAX = {LEN_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_START    = 2'd0,
        OP_POLL     = 2'd1,
        OP_ACK_CONS = 2'd2,
        OP_ACK_SENT = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        PH_HEADER = 2'd0,
        PH_TAIL   = 2'd1,
        PH_HEAD   = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    // One result transaction
    typedef struct packed {
        logic                 overflow_flag;
        logic [TOTAL_W-1:0]   total_captured;
        logic [LEN_W-1:0]     bytes_to_send;
        logic [LEN_W-1:0]     window_length;
        logic [PTR_W-1:0]     window_offset;
        phase_t               window_kind;
    } result_t;

endpackage

`default_nettype wire

// File: design/ring_capture_unwrap_sender_unit.sv
// Top level: read-out sequencer for a circular capture buffer with output skid stage.
`default_nettype none

// Ring capture read-out sequencer.
// Input stream (s_axis_*): one transaction per command. tuser carries the op
// (start, poll, ack consumed, ack sent); tdata carries the captured byte count,
// the overflow flag and the acknowledged length.
// Output stream (m_axis_*): exactly one result transaction per accepted input,
// in order. tuser carries the window kind (header, tail, head, finished);
// tdata carries offset, length, bytes to send, latched total and overflow.
// Each command is applied to the sequencer state in the cycle it is accepted
// and its result is registered. One command per cycle is taken while
// s_axis_tready is high, set by the single register stage of the state update.
// A two-entry output stage (result register plus skid register) holds results
// while the receiver stalls; s_axis_tready drops only when both are full.
// The cfg port writes the channel number (index 0) and onehot_select (index 1)
// on any edge with cfg_we high; write only while no transaction is pending.
// Reset (rst_n low) clears the sequencer to the header phase with zero counts,
// empties the output stage and clears both configuration registers.
module ring_capture_unwrap_sender_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // cfg write port
    input  wire logic                               cfg_we,
    input  wire logic [rcus_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rcus_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input stream
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata: captured_bytes[63:0], overflow_seen[64], ack_length[84:65], zero pad
    input  wire logic [rcus_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // tuser: op[1:0]
    input  wire logic [rcus_pkg::OP_W-1:0]          s_axis_tuser,
    // output stream
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // tdata: window_offset[18:0], window_length[38:19], bytes_to_send[58:39],
    //        total_captured[122:59], overflow_flag[123], zero pad
    output logic [rcus_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    // tuser: window_kind[1:0]
    output logic [rcus_pkg::KIND_W-1:0]             m_axis_tuser
);
    import rcus_pkg::*;

    localparam int unsigned RES_DATA_W = $bits(result_t) - KIND_W;

    // Config registers
    logic [CFG_DATA_W-1:0] chan_id_reg;
    logic                  onehot_select_reg;

    // Sequencer state
    phase_t             phase_reg, phase_next;
    logic [PTR_W-1:0]   write_pointer_reg, write_pointer_next;
    logic               wrapped_reg, wrapped_next;
    logic [LEN_W-1:0]   consumed_reg, consumed_next;
    logic [LEN_W-1:0]   sent_reg, sent_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [LEN_W-1:0]   send_count_reg, send_count_next;
    logic               overflow_reg, overflow_next;

    // Output stage
    result_t out_reg, skid_reg, result_next;
    logic    out_valid_reg, skid_valid_reg;

    // Input field unpacking
    op_t                in_op;
    logic [TOTAL_W-1:0] in_captured;
    logic               in_overflow;
    logic [LEN_W-1:0]   in_ack_len;

    logic in_fire, out_fire;

    // Arithmetic helpers
    logic [LEN_W:0]   cons_sum, sent_sum;
    logic [LEN_W-1:0] cons_sat, sent_sat;
    logic [LEN_W:0]   tail_pos;

    assign in_op       = op_t'(s_axis_tuser);
    assign in_captured = s_axis_tdata[TOTAL_W-1:0];
    assign in_overflow = s_axis_tdata[TOTAL_W];
    assign in_ack_len  = s_axis_tdata[TOTAL_W+LEN_W:TOTAL_W+1];

    assign s_axis_tready = ~skid_valid_reg;
    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign out_fire      = out_valid_reg & m_axis_tready;

    // Saturating offset adds
    assign cons_sum = {1'b0, consumed_reg} + {1'b0, in_ack_len};
    assign sent_sum = {1'b0, sent_reg} + {1'b0, in_ack_len};
    assign cons_sat = cons_sum[LEN_W] ? OFS_MAX : cons_sum[LEN_W-1:0];
    assign sent_sat = sent_sum[LEN_W] ? OFS_MAX : sent_sum[LEN_W-1:0];

    // Next-state logic
    always_comb
    begin
        phase_next         = phase_reg;
        write_pointer_next = write_pointer_reg;
        wrapped_next       = wrapped_reg;
        consumed_next      = consumed_reg;
        sent_next          = sent_reg;
        total_next         = total_reg;
        send_count_next    = send_count_reg;
        overflow_next      = overflow_reg;
        unique case (in_op)
            OP_START:
            begin
                total_next         = in_captured;
                write_pointer_next = in_captured[PTR_W-1:0];
                wrapped_next       = |in_captured[TOTAL_W-1:PTR_W];
                send_count_next    = wrapped_next ? LEN_W'(BUFFER_BYTES)
                                                  : in_captured[LEN_W-1:0];
                overflow_next      = in_overflow;
                consumed_next      = '0;
                sent_next          = '0;
                phase_next         = PH_HEADER;
            end
            OP_POLL:
            begin
            end
            OP_ACK_CONS:
            begin
                consumed_next = cons_sat;
            end
            OP_ACK_SENT:
            begin
                sent_next = sent_sat;
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        if (sent_sat >= LEN_W'(HEADER_BYTES))
                        begin
                            consumed_next = '0;
                            sent_next     = '0;
                            priority if (wrapped_reg)
                                phase_next = PH_TAIL;
                            else if (write_pointer_reg != '0)
                                phase_next = PH_HEAD;
                            else
                                phase_next = PH_DONE;
                        end
                    end
                    PH_TAIL:
                    begin
                        // ends on consumed bytes reaching the buffer end
                        if (({2'b00, write_pointer_reg} + {1'b0, consumed_reg})
                            >= (LEN_W+1)'(BUFFER_BYTES))
                        begin
                            consumed_next = '0;
                            sent_next     = '0;
                            phase_next    = PH_HEAD;
                        end
                    end
                    PH_HEAD:
                    begin
                        if (sent_sat >= {1'b0, write_pointer_reg})
                            phase_next = PH_DONE;
                    end
                    PH_DONE:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    assign tail_pos = {2'b00, write_pointer_next} + {1'b0, consumed_next};

    // Result logic: window as it stands after the command
    always_comb
    begin
        result_next.window_kind    = phase_next;
        result_next.window_offset  = '0;
        result_next.window_length  = '0;
        result_next.bytes_to_send  = send_count_next;
        result_next.total_captured = total_next;
        result_next.overflow_flag  = overflow_next;
        unique case (phase_next)
            PH_HEADER:
            begin
                result_next.window_offset = consumed_next[PTR_W-1:0];
                if (consumed_next < LEN_W'(HEADER_BYTES))
                    result_next.window_length = LEN_W'(HEADER_BYTES) - consumed_next;
            end
            PH_TAIL:
            begin
                result_next.window_offset = tail_pos[PTR_W-1:0];
                if (tail_pos < (LEN_W+1)'(BUFFER_BYTES))
                    result_next.window_length = LEN_W'((LEN_W+1)'(BUFFER_BYTES) - tail_pos);
            end
            PH_HEAD:
            begin
                result_next.window_offset = consumed_next[PTR_W-1:0];
                if ({1'b0, write_pointer_next} > consumed_next)
                    result_next.window_length = {1'b0, write_pointer_next} - consumed_next;
            end
            PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_id_reg       <= '0;
            onehot_select_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CHAN_ID:       chan_id_reg       <= cfg_data;
                CFG_ONEHOT_SELECT: onehot_select_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HEADER;
            write_pointer_reg <= '0;
            wrapped_reg       <= 1'b0;
            consumed_reg      <= '0;
            sent_reg          <= '0;
            total_reg         <= '0;
            send_count_reg    <= '0;
            overflow_reg      <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg         <= phase_next;
            write_pointer_reg <= write_pointer_next;
            wrapped_reg       <= wrapped_next;
            consumed_reg      <= consumed_next;
            sent_reg          <= sent_next;
            total_reg         <= total_next;
            send_count_reg    <= send_count_next;
            overflow_reg      <= overflow_next;
        end
    end

    // Output stage control: result register backed by one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (skid_valid_reg)
            begin
                if (out_fire)
                    skid_valid_reg <= 1'b0;
            end
            else if (in_fire)
            begin
                out_valid_reg <= 1'b1;
                if (out_valid_reg && !m_axis_tready)
                    skid_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output stage payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
                out_reg <= skid_reg;
        end
        else if (in_fire)
        begin
            if (!out_valid_reg || m_axis_tready)
                out_reg <= result_next;
            else
                skid_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.window_kind;
    assign m_axis_tdata  = {{(OUT_TDATA_W - RES_DATA_W){1'b0}},
                            out_reg[$bits(result_t)-1:KIND_W]};

    // Assertions
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while result register empty");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> out_valid_reg)
        else $error("stalled result dropped");

    a_start_to_header: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_op == OP_START) |=> (phase_reg == PH_HEADER
            && consumed_reg == '0 && sent_reg == '0))
        else $error("start did not restart in header phase");

    a_send_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        send_count_reg <= LEN_W'(BUFFER_BYTES))
        else $error("send count beyond buffer size");

    a_cfg_kept: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_we |=> ($stable(chan_id_reg) && $stable(onehot_select_reg)))
        else $error("config register changed without a write");

endmodule

`default_nettype wire

// File: dv/ring_window_checker.sv
// Checker: predicts the read-out window for every command and compares each result transaction.
`timescale 1ns / 100ps

module ring_window_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [rcus_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rcus_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              s_axis_tvalid,
    input  wire logic                              s_axis_tready,
    // tdata: captured_bytes[63:0], overflow_seen[64], ack_length[84:65], zero pad
    input  wire logic [rcus_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // tuser: op[1:0]
    input  wire logic [rcus_pkg::OP_W-1:0]         s_axis_tuser,
    input  wire logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // tdata: window_offset[18:0], window_length[38:19], bytes_to_send[58:39],
    //        total_captured[122:59], overflow_flag[123], zero pad
    input  wire logic [rcus_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // tuser: window_kind[1:0]
    input  wire logic [rcus_pkg::KIND_W-1:0]       m_axis_tuser,
    output int unsigned                            mismatch_count,
    output int unsigned                            pending_count,
    output int unsigned                            window_count
);
    import rcus_pkg::*;

    // Sequencer state as predicted
    phase_t               seq_phase;
    logic [PTR_W-1:0]     wr_ptr;
    logic                 buf_wrapped;
    logic [LEN_W-1:0]     consumed_ofs;
    logic [LEN_W-1:0]     sent_ofs;
    logic [LEN_W-1:0]     send_bytes;
    logic [TOTAL_W-1:0]   total_bytes;
    logic                 ovf_latched;

    // Configuration copy; the result stream never shows it
    logic [7:0]           chan_id_reg;
    logic                 onehot_reg;

    result_t              window_q[$];

    function automatic logic [LEN_W-1:0] add_sat(logic [LEN_W-1:0] a, logic [LEN_W-1:0] b);
        logic [LEN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, OFS_MAX}) ? OFS_MAX : s[LEN_W-1:0];
    endfunction

    // Apply one command to the predicted state and return the window after it
    function automatic result_t apply_command(op_t op, logic [TOTAL_W-1:0] cap_bytes,
                                              logic ovf_in, logic [LEN_W-1:0] ack_len);
        result_t        r;
        logic [LEN_W:0] tail_pos;
        case (op)
            OP_START:
            begin
                total_bytes  = cap_bytes;
                wr_ptr       = cap_bytes[PTR_W-1:0];
                buf_wrapped  = |cap_bytes[TOTAL_W-1:PTR_W];
                send_bytes   = buf_wrapped ? LEN_W'(BUFFER_BYTES) : cap_bytes[LEN_W-1:0];
                ovf_latched  = ovf_in;
                consumed_ofs = '0;
                sent_ofs     = '0;
                seq_phase    = PH_HEADER;
            end
            OP_ACK_CONS:
            begin
                consumed_ofs = add_sat(consumed_ofs, ack_len);
            end
            OP_ACK_SENT:
            begin
                sent_ofs = add_sat(sent_ofs, ack_len);
                tail_pos = {2'b00, wr_ptr} + {1'b0, consumed_ofs};
                case (seq_phase)
                    PH_HEADER:
                    begin
                        if (sent_ofs >= LEN_W'(HEADER_BYTES))
                        begin
                            consumed_ofs = '0;
                            sent_ofs     = '0;
                            if (buf_wrapped)
                                seq_phase = PH_TAIL;
                            else if (wr_ptr != '0)
                                seq_phase = PH_HEAD;
                            else
                                seq_phase = PH_DONE;
                        end
                    end
                    // tail ends on consumed bytes, not sent bytes
                    PH_TAIL:
                    begin
                        if (tail_pos >= (LEN_W+1)'(BUFFER_BYTES))
                        begin
                            consumed_ofs = '0;
                            sent_ofs     = '0;
                            seq_phase    = PH_HEAD;
                        end
                    end
                    PH_HEAD:
                    begin
                        if (sent_ofs >= {1'b0, wr_ptr})
                            seq_phase = PH_DONE;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        // Window of the current phase, lengths floored at zero
        tail_pos = {2'b00, wr_ptr} + {1'b0, consumed_ofs};
        r.window_kind = seq_phase;
        case (seq_phase)
            PH_HEADER:
            begin
                r.window_offset = consumed_ofs[PTR_W-1:0];
                r.window_length = (consumed_ofs < LEN_W'(HEADER_BYTES)) ?
                                  LEN_W'(HEADER_BYTES) - consumed_ofs : '0;
            end
            PH_TAIL:
            begin
                r.window_offset = tail_pos[PTR_W-1:0];
                r.window_length = (tail_pos < (LEN_W+1)'(BUFFER_BYTES)) ?
                                  LEN_W'((LEN_W+1)'(BUFFER_BYTES) - tail_pos) : '0;
            end
            PH_HEAD:
            begin
                r.window_offset = consumed_ofs[PTR_W-1:0];
                r.window_length = (consumed_ofs < {1'b0, wr_ptr}) ?
                                  {1'b0, wr_ptr} - consumed_ofs : '0;
            end
            default:
            begin
                r.window_offset = '0;
                r.window_length = '0;
            end
        endcase
        r.bytes_to_send  = send_bytes;
        r.total_captured = total_bytes;
        r.overflow_flag  = ovf_latched;
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t ns: %s expected 0x%0h actual 0x%0h", $time, name, want_v, got_v);
            mismatch_count++;
        end
    endtask

    // Watch both streams and the cfg port
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            seq_phase       = PH_HEADER;
            wr_ptr          = '0;
            buf_wrapped     = 1'b0;
            consumed_ofs    = '0;
            sent_ofs        = '0;
            send_bytes      = '0;
            total_bytes     = '0;
            ovf_latched     = 1'b0;
            chan_id_reg     = '0;
            onehot_reg      = 1'b0;
            window_q.delete();
            mismatch_count  = 0;
            window_count    = 0;
            pending_count   = 0;
        end
        else
        begin
            // result transaction: compare with the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                window_count++;
                if (window_q.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none, actual kind %0d tdata 0x%0h",
                             $time, m_axis_tuser, m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = window_q.pop_front();
                    check_field("window_kind", 64'(want.window_kind), 64'(m_axis_tuser));
                    check_field("window_offset", 64'(want.window_offset), 64'(m_axis_tdata[18:0]));
                    check_field("window_length", 64'(want.window_length), 64'(m_axis_tdata[38:19]));
                    check_field("bytes_to_send", 64'(want.bytes_to_send), 64'(m_axis_tdata[58:39]));
                    check_field("total_captured", want.total_captured, m_axis_tdata[122:59]);
                    check_field("overflow_flag", 64'(want.overflow_flag), 64'(m_axis_tdata[123]));
                end
            end

            if (cfg_we)
            begin
                if (cfg_index == CFG_CHAN_ID)
                    chan_id_reg = cfg_data[7:0];
                else if (cfg_index == CFG_ONEHOT_SELECT)
                    onehot_reg = cfg_data[0];
            end

            // command transaction: predict its window
            if (s_axis_tvalid && s_axis_tready)
                window_q.push_back(apply_command(op_t'(s_axis_tuser), s_axis_tdata[63:0],
                                                 s_axis_tdata[64], s_axis_tdata[84:65]));

            pending_count = window_q.size();
        end
    end

endmodule

// File: dv/tb_ring_capture_unwrap_sender_unit.sv
// Testbench top: drives read-out sessions into the ring capture sequencer and gives the verdict.
`timescale 1ns / 100ps

module tb_ring_capture_unwrap_sender_unit;
    import rcus_pkg::*;

    localparam int unsigned ITEM_TARGET  = 825;
    localparam int unsigned QUIET_ITEMS  = 120;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned MAX_ACK      = BUFFER_BYTES;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata;
    logic [OP_W-1:0]         s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic [KIND_W-1:0]       m_axis_tuser;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned checked;
    int unsigned sent_items;
    int unsigned sessions;
    int unsigned cycles;
    bit          steady;

    ring_capture_unwrap_sender_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    ring_window_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .mismatch_count (mismatches),
        .pending_count  (pending),
        .window_count   (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("Watchdog expired after %0d cycles, %0d results pending", cycles, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver backpressure: random stall bursts until the quiet tail of the run
    initial
    begin
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!steady && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // One command transaction; valid stays high after the handshake
    task automatic send_command(op_t op, logic [63:0] cap_bytes, logic ovf, logic [19:0] len);
        if (sent_items + QUIET_ITEMS >= ITEM_TARGET)
            steady = 1'b1;
        if (!steady && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, len, ovf, cap_bytes};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sent_items++;
    endtask

    task automatic send_noise();
        send_command(op_t'($urandom_range(0, 3)), {32'($urandom), 32'($urandom)},
                     1'($urandom), 20'($urandom_range(0, MAX_ACK)));
    endtask

    // Stop sending and wait until every result has come back
    task automatic drain_all();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(logic [7:0] chan, logic onehot);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CHAN_ID;
        cfg_data  <= CFG_DATA_W'(chan);
        @(posedge clk);
        cfg_index <= CFG_ONEHOT_SELECT;
        cfg_data  <= CFG_DATA_W'(onehot);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Acknowledge a window of span bytes in random chunks; may abandon midway
    task automatic walk_window(int unsigned span, output bit broke);
        int unsigned rem;
        int unsigned chunk;
        rem   = span;
        broke = 1'b0;
        while (rem != 0)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                broke = 1'b1;
                return;
            end
            if ($urandom_range(0, 9) == 0)
                send_noise();
            case ($urandom_range(0, 5))
                0, 1:    chunk = rem;
                2:       chunk = rem + $urandom_range(1, 40);
                default: chunk = $urandom_range(1, rem);
            endcase
            if (chunk > MAX_ACK)
                chunk = MAX_ACK;
            send_command(OP_ACK_CONS, {32'($urandom), 32'($urandom)}, 1'($urandom), 20'(chunk));
            if ($urandom_range(0, 2) == 0)
                send_command(OP_POLL, {32'($urandom), 32'($urandom)}, 1'($urandom),
                             20'($urandom_range(0, MAX_ACK)));
            send_command(OP_ACK_SENT, {32'($urandom), 32'($urandom)}, 1'($urandom), 20'(chunk));
            rem = (chunk >= rem) ? 0 : rem - chunk;
        end
    endtask

    // Start, header, tail, head, then a few commands in the finished phase
    task automatic run_session();
        logic [63:0]       cap_bytes;
        logic [PTR_W-1:0]  ptr;
        logic              wrapped;
        bit                broke;
        case ($urandom_range(0, 5))
            0:       cap_bytes = 64'($urandom_range(0, 2000));
            1:       cap_bytes = 64'($urandom_range(0, BUFFER_BYTES - 1));
            2:       cap_bytes = 64'(BUFFER_BYTES) + 64'($urandom_range(0, BUFFER_BYTES - 1));
            3:       cap_bytes = (64'($urandom_range(1, 8)) << PTR_W) + 64'(BUFFER_BYTES)
                                 - 64'($urandom_range(1, 64));
            4:       cap_bytes = {32'($urandom), 32'($urandom)};
            default: cap_bytes = 64'($urandom_range(1, 4096)) << PTR_W;
        endcase
        ptr     = cap_bytes[PTR_W-1:0];
        wrapped = |cap_bytes[63:PTR_W];
        sessions++;
        send_command(OP_START, cap_bytes, 1'($urandom), 20'($urandom_range(0, MAX_ACK)));
        walk_window(HEADER_BYTES, broke);
        if (broke)
            return;
        if (wrapped)
        begin
            walk_window(BUFFER_BYTES - 32'(ptr), broke);
            if (broke)
                return;
        end
        if (ptr != '0)
        begin
            walk_window(32'(ptr), broke);
            if (broke)
                return;
        end
        repeat ($urandom_range(1, 3))
            send_command(op_t'($urandom_range(1, 3)), {32'($urandom), 32'($urandom)},
                         1'($urandom), 20'($urandom_range(0, MAX_ACK)));
    endtask

    // Main sequence
    initial
    begin
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_POLL;
        sent_items    = 0;
        sessions      = 0;
        steady        = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_config(8'hFF, 1'b1);

        // commands on the reset state, before any start
        send_command(OP_POLL, '0, 1'b0, '0);
        send_command(OP_ACK_CONS, '0, 1'b0, 20'd7);
        send_command(OP_ACK_SENT, '0, 1'b0, 20'd3);
        // empty capture: header overrun, then straight to finished
        send_command(OP_START, 64'd0, 1'b0, '0);
        send_command(OP_ACK_CONS, '0, 1'b0, 20'd20);
        send_command(OP_ACK_SENT, '0, 1'b0, 20'd15);
        send_command(OP_ACK_CONS, '0, 1'b0, 20'd5);
        // largest count: wrapped, pointer at the last byte, offsets saturate
        send_command(OP_START, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '0);
        send_command(OP_ACK_SENT, '0, 1'b0, 20'(MAX_ACK));
        send_command(OP_ACK_CONS, '0, 1'b0, 20'(MAX_ACK));
        send_command(OP_ACK_CONS, '0, 1'b0, 20'(MAX_ACK));
        send_command(OP_POLL, '0, 1'b0, '0);
        send_command(OP_ACK_SENT, '0, 1'b0, 20'd0);
        send_command(OP_ACK_SENT, '0, 1'b0, 20'(MAX_ACK));
        // exactly one buffer: wrapped with pointer zero
        send_command(OP_START, 64'(BUFFER_BYTES), 1'b0, '0);
        send_command(OP_ACK_SENT, '0, 1'b0, 20'd15);
        send_command(OP_ACK_CONS, '0, 1'b0, 20'(MAX_ACK));
        send_command(OP_ACK_SENT, '0, 1'b0, 20'd1);
        send_command(OP_ACK_SENT, '0, 1'b0, 20'd0);
        // one byte short of a buffer: head only, overrun window
        send_command(OP_START, 64'(BUFFER_BYTES - 1), 1'b1, '0);
        send_command(OP_ACK_SENT, '0, 1'b0, 20'd15);
        send_command(OP_ACK_CONS, '0, 1'b0, 20'(MAX_ACK));
        send_command(OP_ACK_SENT, '0, 1'b0, 20'(MAX_ACK));

        drain_all();
        set_config(8'($urandom), 1'($urandom));

        while (sent_items < ITEM_TARGET)
        begin
            if (sessions == 12)
            begin
                drain_all();
                set_config(8'h00, 1'b0);
            end
            run_session();
        end

        drain_all();
        $display("Covered %0d commands in %0d random read-out sessions plus directed cases",
                 sent_items, sessions);
        $display("%0d result transactions checked, %0d field mismatches", checked, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
